@@ src/wlh_pkg.sv @@
// ----------------------------------------------------------------------------
// wlh_pkg
// Shared types and constants of the word length histogram: op codes,
// separator bytes and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package wlh_pkg;

  // Input op codes
  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOS  = 1'b1
  } wlh_op_e;

  // Separator bytes
  localparam logic [7:0] SEP_SPACE   = 8'h20;
  localparam logic [7:0] SEP_NEWLINE = 8'h0A;
  localparam logic [7:0] SEP_TAB     = 8'h09;

  // Register widths and reset value
  localparam int unsigned CAT_W       = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned BIN_LEN_W   = 5;
  localparam logic [CAT_W-1:0] CAT_RESET = 5'd16;

  // Controller to datapath
  typedef struct packed {
    logic char_step;  // character byte transfer
    logic eos;        // end-of-stream transfer: close the pending word
    logic dump_step;  // emit and clear one bin
  } wlh_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dump_last;  // dump index sits on the final bin
  } wlh_sts_t;

endpackage

@@ src/wlh_ctrl.sv @@
// ----------------------------------------------------------------------------
// wlh_ctrl
// Controller: accepts items, decodes them into datapath commands and walks
// the dump sequence.
// ----------------------------------------------------------------------------
module wlh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              op_i,
  input  wlh_pkg::wlh_sts_t sts_i,
  output wlh_pkg::wlh_cmd_t cmd_o,
  output logic              busy
);
  import wlh_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_DUMP);

  // Command decode
  always_comb begin
    cmd_o.char_step = accept && (wlh_op_e'(op_i) == OP_CHAR);
    cmd_o.eos       = accept && (wlh_op_e'(op_i) == OP_EOS);
    cmd_o.dump_step = (state_q == ST_DUMP);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.eos) state_d = ST_DUMP;
      end
      ST_DUMP: begin
        if (sts_i.dump_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // End of stream always starts a dump
  a_eos_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eos |=> (state_q == ST_DUMP))
    else $error("end of stream did not start a dump");

  // Dump ends on the final bin
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) && sts_i.dump_last |=> (state_q == ST_IDLE))
    else $error("dump did not end after the final bin");

endmodule

@@ src/wlh_datapath.sv @@
// ----------------------------------------------------------------------------
// wlh_datapath
// Datapath: word length counter, bin store with saturating increment,
// dump index, result registers and the category register.
// ----------------------------------------------------------------------------
module wlh_datapath #(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wlh_pkg::wlh_cmd_t             cmd_i,
  output wlh_pkg::wlh_sts_t             sts_o,
  input  logic [wlh_pkg::CHAR_W-1:0]    char_code_i,
  input  logic                          cfg_we_i,
  input  logic [wlh_pkg::CAT_W-1:0]     cfg_num_categories_i,
  output logic                          result_valid_o,
  output logic [wlh_pkg::BIN_LEN_W-1:0] bin_length_o,
  output logic [wlh_pkg::COUNT_W-1:0]   bin_count_o,
  output logic                          last_bin_o
);
  import wlh_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 2);
  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CMP_W = (LEN_W > CAT_W) ? LEN_W : CAT_W;
  localparam logic [LEN_W-1:0] LEN_SAT  = LEN_W'(MAX_LEN + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LEN - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [COUNT_W-1:0] store_q [MAX_LEN];
  logic [LEN_W-1:0]   word_len_q;
  logic               in_word_q;
  logic [CAT_W-1:0]   num_cat_q;
  logic [IDX_W-1:0]   dump_idx_q;

  logic               is_sep;
  logic               close_word;
  logic               close_hit;
  logic [LEN_W-1:0]   len_m1;
  logic [IDX_W-1:0]   hit_idx;
  logic [COUNT_W-1:0] hit_val;

  logic               result_valid_q;
  logic [BIN_LEN_W-1:0] bin_length_q;
  logic [COUNT_W-1:0] bin_count_q;
  logic               last_bin_q;

  // Byte classification and word close
  assign is_sep     = (char_code_i == SEP_SPACE) || (char_code_i == SEP_NEWLINE) ||
                      (char_code_i == SEP_TAB);
  assign close_word = cmd_i.eos || (cmd_i.char_step && is_sep);
  assign close_hit  = close_word && in_word_q && (word_len_q != '0) &&
                      (CMP_W'(word_len_q) <= CMP_W'(num_cat_q)) &&
                      (CMP_W'(word_len_q) <= CMP_W'(MAX_LEN));
  assign len_m1     = word_len_q - LEN_W'(1);
  assign hit_idx    = len_m1[IDX_W-1:0];
  assign hit_val    = store_q[hit_idx];

  assign sts_o.dump_last = (dump_idx_q == IDX_LAST);

  // Word tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_len_q <= '0;
      in_word_q  <= 1'b0;
    end else if (close_word) begin
      word_len_q <= '0;
      in_word_q  <= 1'b0;
    end else if (cmd_i.char_step) begin
      in_word_q <= 1'b1;
      if (word_len_q != LEN_SAT) word_len_q <= word_len_q + LEN_W'(1);
    end
  end

  // Category register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cat_q <= CAT_RESET;
    end else if (cfg_we_i) begin
      num_cat_q <= cfg_num_categories_i;
    end
  end

  // Bin store: saturating increment on a counted word, clear as it is dumped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEN; i++) store_q[i] <= '0;
    end else if (close_hit) begin
      if (hit_val != COUNT_MAX) store_q[hit_idx] <= hit_val + COUNT_W'(1);
    end else if (cmd_i.dump_step) begin
      store_q[dump_idx_q] <= '0;
    end
  end

  // Dump index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_idx_q <= '0;
    end else if (cmd_i.dump_step) begin
      dump_idx_q <= sts_o.dump_last ? '0 : dump_idx_q + IDX_W'(1);
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.dump_step;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.dump_step) begin
      bin_length_q <= BIN_LEN_W'(32'(dump_idx_q) + 32'd1);
      bin_count_q  <= store_q[dump_idx_q];
      last_bin_q   <= sts_o.dump_last;
    end
  end

  assign result_valid_o = result_valid_q;
  assign bin_length_o   = bin_length_q;
  assign bin_count_o    = bin_count_q;
  assign last_bin_o     = last_bin_q && result_valid_q;

  // A result only follows a dump step
  a_res_from_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(cmd_i.dump_step))
    else $error("result without a dump step");

  // No word activity while dumping
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dump_step |-> !(cmd_i.char_step || cmd_i.eos))
    else $error("item transfer during dump");

  // The final bin is followed by a fresh index
  a_idx_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dump_step && sts_o.dump_last |=> (dump_idx_q == '0))
    else $error("dump index did not wrap");

endmodule

@@ src/word_length_histogram.sv @@
// ----------------------------------------------------------------------------
// word_length_histogram
// Counts word lengths in a byte stream and dumps the histogram on end of
// stream.
// ----------------------------------------------------------------------------
// Character bytes are taken one per cycle: busy stays low and start may be
// held high on every cycle. An end-of-stream item closes any pending word in
// its own cycle and then holds busy high while the sequencer walks the bin
// store one bin per cycle, emitting and clearing each bin. Results appear on
// consecutive cycles, the first once the end-of-stream transfer has passed
// through the state register and then the result registers, each marked by
// result_valid_o for one cycle; the receiver must take them as they come.
// The category register may be written whenever busy is low.
module word_length_histogram #(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [wlh_pkg::CHAR_W-1:0]    char_code_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wlh_pkg::CAT_W-1:0]     cfg_num_categories_i,
  output logic                          result_valid_o,
  output logic [wlh_pkg::BIN_LEN_W-1:0] bin_length_o,
  output logic [wlh_pkg::COUNT_W-1:0]   bin_count_o,
  output logic                          last_bin_o
);
  import wlh_pkg::*;

  wlh_cmd_t cmd;
  wlh_sts_t sts;
  logic     cfg_we;

  // Configuration transfer
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  wlh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  wlh_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .char_code_i          (char_code_i),
    .cfg_we_i             (cfg_we),
    .cfg_num_categories_i (cfg_num_categories_i),
    .result_valid_o       (result_valid_o),
    .bin_length_o         (bin_length_o),
    .bin_count_o          (bin_count_o),
    .last_bin_o           (last_bin_o)
  );

endmodule

@@ tb/word_length_histogram_tb.sv @@
// ----------------------------------------------------------------------------
// word_length_histogram_tb
// Self-checking testbench for the word length histogram. A short directed
// sequence covers separators, near-separator bytes, an empty dump and a word
// pending at end of stream. Random streams of words then run under several
// category settings with varying sender gaps. Every dumped bin is checked
// against a predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_length_histogram_tb;
  import wlh_pkg::*;

  localparam int unsigned MAX_LEN = 16;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 op_i;
  logic [CHAR_W-1:0]    char_code_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CAT_W-1:0]     cfg_num_categories_i;
  logic                 result_valid_o;
  logic [BIN_LEN_W-1:0] bin_length_o;
  logic [COUNT_W-1:0]   bin_count_o;
  logic                 last_bin_o;

  // One dumped histogram bin
  typedef struct {
    logic [BIN_LEN_W-1:0] length;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } bin_result_t;

  function automatic bit is_sep(logic [CHAR_W-1:0] b);
    return b == SEP_SPACE || b == SEP_NEWLINE || b == SEP_TAB;
  endfunction

  // Histogram predictor and queue of bins still due from the block
  class bin_scoreboard;
    logic [COUNT_W-1:0] tally [MAX_LEN];
    int unsigned        word_len;
    bit                 in_word;
    int unsigned        categories;
    bin_result_t        bins_due [$];
    int                 errors;

    function new();
      foreach (tally[k]) tally[k] = '0;
      word_len   = 0;
      in_word    = 1'b0;
      categories = CAT_RESET;
      errors     = 0;
    endfunction

    function void set_categories(logic [CAT_W-1:0] v);
      categories = v;
    endfunction

    // Count the word that just ended, if its length has a live bin
    function void close_word();
      if (in_word && word_len >= 1 && word_len <= categories && word_len <= MAX_LEN) begin
        if (tally[word_len-1] != '1) tally[word_len-1]++;
      end
      word_len = 0;
      in_word  = 1'b0;
    endfunction

    function void note_item(wlh_op_e op, logic [CHAR_W-1:0] ch);
      bin_result_t r;
      if (op == OP_CHAR) begin
        if (is_sep(ch)) begin
          close_word();
        end else begin
          in_word = 1'b1;
          if (word_len < MAX_LEN + 1) word_len++;
        end
        return;
      end
      // End of stream: flush the pending word, then every bin in order
      close_word();
      for (int k = 0; k < MAX_LEN; k++) begin
        r.length = BIN_LEN_W'(k + 1);
        r.count  = tally[k];
        r.last   = (k == MAX_LEN - 1);
        bins_due.push_back(r);
        tally[k] = '0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_bin(logic [BIN_LEN_W-1:0] len, logic [COUNT_W-1:0] cnt, logic last);
      bin_result_t want;
      if (bins_due.size() == 0) begin
        report($sformatf("unexpected bin length=%0d count=%0d last=%0b", len, cnt, last));
        return;
      end
      want = bins_due.pop_front();
      if (len !== want.length)
        report($sformatf("bin_length got %0d want %0d", len, want.length));
      if (cnt !== want.count)
        report($sformatf("bin %0d count got %0d want %0d", want.length, cnt, want.count));
      if (last !== want.last)
        report($sformatf("bin %0d last_bin got %0b want %0b", want.length, last, want.last));
    endtask
  endclass

  bin_scoreboard sb;
  int            idle_pct;
  int            items_sent;
  int unsigned   cur_cat;

  word_length_histogram #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .op_i                (op_i),
    .char_code_i         (char_code_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_num_categories_i(cfg_num_categories_i),
    .result_valid_o      (result_valid_o),
    .bin_length_o        (bin_length_o),
    .bin_count_o         (bin_count_o),
    .last_bin_o          (last_bin_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watch transfers on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_categories(cfg_num_categories_i);
      if (start && !busy) sb.note_item(wlh_op_e'(op_i), char_code_i);
      if (result_valid_o) sb.check_bin(bin_length_o, bin_count_o, last_bin_o);
    end
  end

  // Present one item, with a random gap ahead of it, and wait for its transfer
  task automatic send_item(wlh_op_e op, logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    op_i        <= op;
    char_code_i <= ch;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] word_byte();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(255)); while (is_sep(b));
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] sep_byte();
    case ($urandom_range(2))
      0:       return SEP_SPACE;
      1:       return SEP_NEWLINE;
      default: return SEP_TAB;
    endcase
  endfunction

  // One stream of words closed by end of stream; a few are empty or noisy
  task automatic send_stream();
    int n_words;
    int len;
    int n_sep;
    int top;
    if ($urandom_range(99) < 5) begin
      send_item(OP_EOS, CHAR_W'($urandom_range(255)));
      return;
    end
    if ($urandom_range(99) < 15) send_item(OP_CHAR, sep_byte());
    top     = (cur_cat > MAX_LEN) ? MAX_LEN : cur_cat;
    n_words = $urandom_range(1, 5);
    for (int w = 0; w < n_words; w++) begin
      case ($urandom_range(9))
        0:       len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
        1, 2:    len = $urandom_range(1, MAX_LEN + 1);
        default: len = $urandom_range(1, top + 1);
      endcase
      repeat (len) send_item(OP_CHAR, word_byte());
      n_sep = ($urandom_range(99) < 20) ? $urandom_range(2, 3) : 1;
      if (w < n_words - 1 || $urandom_range(1))
        repeat (n_sep) send_item(OP_CHAR, sep_byte());
    end
    send_item(OP_EOS, CHAR_W'($urandom_range(255)));
  endtask

  // Let all due bins arrive and the block go quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.bins_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_categories(logic [CAT_W-1:0] v);
    cfg_valid_i          <= 1'b1;
    cfg_num_categories_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_cat = v;
  endtask

  // Stimulus
  initial begin
    logic [CAT_W-1:0] cat_plan [7];
    int               phase_end;
    sb                   = new();
    cat_plan             = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd16, 5'd0};
    cat_plan[6]          = CAT_W'($urandom_range(31));
    idle_pct             = 11;
    items_sent           = 0;
    cur_cat              = CAT_RESET;
    rst_ni               = 1'b0;
    start                = 1'b0;
    op_i                 = OP_CHAR;
    char_code_i          = '0;
    cfg_valid_i          = 1'b0;
    cfg_num_categories_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dump, one-letter word, extreme bytes, near-separator
    // bytes, doubled separators, then a word still open at end of stream
    send_item(OP_EOS, 8'h00);
    send_item(OP_CHAR, 8'h61);
    send_item(OP_CHAR, SEP_SPACE);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, SEP_NEWLINE);
    send_item(OP_CHAR, 8'h08);
    send_item(OP_CHAR, 8'h0B);
    send_item(OP_CHAR, 8'h1F);
    send_item(OP_CHAR, 8'h21);
    send_item(OP_CHAR, SEP_TAB);
    send_item(OP_CHAR, SEP_SPACE);
    send_item(OP_CHAR, SEP_SPACE);
    send_item(OP_CHAR, 8'h78);
    send_item(OP_CHAR, 8'h79);
    send_item(OP_EOS, 8'hFF);

    // Random streams under each category setting
    for (int p = 0; p < 7; p++) begin
      settle();
      idle_pct = (p < 2) ? 11 : (p < 4) ? 71 : 0;
      write_categories(cat_plan[p]);
      phase_end = items_sent + 8;
      while (items_sent < phase_end) send_stream();
    end

    // Drain, bounded
    start <= 1'b0;
    for (int i = 0; i < 2000 && sb.bins_due.size() != 0; i++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.bins_due.size() != 0)
      sb.report($sformatf("%0d bins never arrived", sb.bins_due.size()));

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/wlh_pkg.sv
src/wlh_ctrl.sv
src/wlh_datapath.sv
src/word_length_histogram.sv
tb/word_length_histogram_tb.sv
